// File: rtl/dste_pkg.sv
// ----------------------------------------------------------------------------
// dste_pkg
// types and constants for the der scalar tag-length-value encoder
// ----------------------------------------------------------------------------
package dste_pkg;

    // kind selector codes
    localparam logic [1:0] KIND_BOOLEAN    = 2'd0;
    localparam logic [1:0] KIND_SIGNED     = 2'd1;
    localparam logic [1:0] KIND_UNSIGNED   = 2'd2;
    localparam logic [1:0] KIND_ENUMERATED = 2'd3;

    // der universal tags
    localparam logic [7:0] TAG_BOOLEAN    = 8'h01;
    localparam logic [7:0] TAG_INTEGER    = 8'h02;
    localparam logic [7:0] TAG_ENUMERATED = 8'h0A;

    localparam logic [7:0] BYTE_ONES  = 8'hFF;
    localparam logic [7:0] BYTE_ZEROS = 8'h00;

    // tag + length + up to nine content bytes
    localparam int MAX_BYTES   = 11;
    localparam int MAX_CONTENT = 9;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [63:0] value_bits;
        logic [7:0]  space_left;
    } dste_in_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last;
        logic       overflow;
    } dste_out_t;

endpackage

// File: rtl/der_scalar_tlv_encoder.sv
// path: an accepted item passes the stage 1, stage 2, serialiser and output registers to m_data
// throughput: one result byte per cycle while m_ready does not stall the output; an encoding
// has 3 bytes for a boolean, 3 to 11 for integers and 1 on overflow, all sent by the
// single byte serialiser at the end of the pipeline
// reset: aresetn low at a clock edge empties every stage and the output register
// ----------------------------------------------------------------------------
// der_scalar_tlv_encoder
// pipelined der encoder for boolean, integer and enumerated scalars
// ----------------------------------------------------------------------------
module der_scalar_tlv_encoder (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  dste_pkg::dste_in_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output dste_pkg::dste_out_t m_data
);

    localparam int MAX_BYTES_L   = dste_pkg::MAX_BYTES;
    localparam int MAX_CONTENT_L = dste_pkg::MAX_CONTENT;

    // stage 1: sign and sign-folded value
    logic        s1_valid_reg, s1_valid_next;
    logic [1:0]  s1_kind_reg;
    logic [63:0] s1_value_reg, s1_value_next;
    logic [63:0] s1_w_reg, s1_w_next;
    logic        s1_neg_reg, s1_neg_next;
    logic [7:0]  s1_space_reg;

    // stage 2: content length
    logic        s2_valid_reg, s2_valid_next;
    logic [1:0]  s2_kind_reg;
    logic [63:0] s2_value_reg;
    logic        s2_neg_reg;
    logic [3:0]  s2_n_reg, s2_n_next;
    logic [7:0]  s2_space_reg;

    // stage 3: byte serialiser
    logic        ser_valid_reg, ser_valid_next;
    logic [7:0]  ser_buf_reg [MAX_BYTES_L];
    logic [7:0]  ser_buf_next [MAX_BYTES_L];
    logic [3:0]  ser_cnt_reg, ser_cnt_next;
    logic        ser_ovf_reg, ser_ovf_next;

    // output register
    logic                m_valid_reg, m_valid_next;
    dste_pkg::dste_out_t m_data_reg, m_data_next;

    logic out_load, ser_done, ser_take, s2_ready, s1_ready;

    logic [7:0]  ext_bytes [MAX_CONTENT_L];
    logic [7:0]  load_buf  [MAX_BYTES_L];
    logic [3:0]  load_total;
    logic        load_ovf;

    // handshake chain
    assign out_load = ser_valid_reg && (!m_valid_reg || m_ready);
    assign ser_done = out_load && (ser_cnt_reg == 4'd1);
    assign ser_take = !ser_valid_reg || ser_done;
    assign s2_ready = !s2_valid_reg || ser_take;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign s_ready  = s1_ready;

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // stage 1
    always_comb begin
        logic [63:0] v;
        v = s_data.value_bits;
        s1_valid_next = s1_ready ? s_valid : s1_valid_reg;
        s1_neg_next   = 1'b0;
        case (s_data.cmd)
            dste_pkg::KIND_BOOLEAN: begin
                s1_value_next = {56'd0, (v != 64'd0) ? dste_pkg::BYTE_ONES
                                                     : dste_pkg::BYTE_ZEROS};
            end
            dste_pkg::KIND_SIGNED: begin
                s1_value_next = v;
                s1_neg_next   = v[63];
            end
            dste_pkg::KIND_ENUMERATED: begin
                s1_value_next = {32'd0, v[31:0]};
            end
            default: begin
                s1_value_next = v;
            end
        endcase
        s1_w_next = s1_neg_next ? ~s1_value_next : s1_value_next;
    end

    // stage 2: smallest n whose top content bit matches the sign, or one for a boolean
    always_comb begin
        s2_valid_next = s2_ready ? s1_valid_reg : s2_valid_reg;
        s2_n_next     = 4'(MAX_CONTENT_L);
        for (int k = MAX_CONTENT_L - 1; k >= 1; k--) begin
            if ((s1_w_reg >> (8 * k - 1)) == 64'd0) begin
                s2_n_next = 4'(k);
            end
        end
        if (s1_kind_reg == dste_pkg::KIND_BOOLEAN) begin
            s2_n_next = 4'd1;
        end
    end

    // stage 3 load image
    always_comb begin
        logic [71:0] ext;
        logic [3:0]  sel;
        ext = {s2_neg_reg ? dste_pkg::BYTE_ONES : dste_pkg::BYTE_ZEROS, s2_value_reg};
        for (int j = 0; j < MAX_CONTENT_L; j++) begin
            ext_bytes[j] = ext[8 * j +: 8];
        end
        for (int i = 0; i < MAX_BYTES_L; i++) begin
            load_buf[i] = 8'd0;
        end
        case (s2_kind_reg)
            dste_pkg::KIND_BOOLEAN:    load_buf[0] = dste_pkg::TAG_BOOLEAN;
            dste_pkg::KIND_ENUMERATED: load_buf[0] = dste_pkg::TAG_ENUMERATED;
            default:                   load_buf[0] = dste_pkg::TAG_INTEGER;
        endcase
        load_buf[1] = {4'd0, s2_n_reg};
        for (int i = 0; i < MAX_CONTENT_L; i++) begin
            sel = 4'(s2_n_reg - 4'(i) - 4'd1);
            if (4'(i) < s2_n_reg) begin
                load_buf[2 + i] = ext_bytes[sel];
            end
        end
        load_total = 4'(s2_n_reg + 4'd2);
        load_ovf   = {4'd0, load_total} > s2_space_reg;
        if (load_ovf) begin
            for (int i = 0; i < MAX_BYTES_L; i++) begin
                load_buf[i] = 8'd0;
            end
            load_total = 4'd1;
        end
    end

    // serialiser
    always_comb begin
        ser_valid_next = ser_valid_reg;
        ser_cnt_next   = ser_cnt_reg;
        ser_ovf_next   = ser_ovf_reg;
        for (int i = 0; i < MAX_BYTES_L; i++) begin
            ser_buf_next[i] = ser_buf_reg[i];
        end
        if (ser_take) begin
            ser_valid_next = s2_valid_reg;
            ser_cnt_next   = load_total;
            ser_ovf_next   = load_ovf;
            for (int i = 0; i < MAX_BYTES_L; i++) begin
                ser_buf_next[i] = load_buf[i];
            end
        end else if (out_load) begin
            ser_cnt_next = ser_cnt_reg - 4'd1;
            for (int i = 0; i < MAX_BYTES_L - 1; i++) begin
                ser_buf_next[i] = ser_buf_reg[i + 1];
            end
            ser_buf_next[MAX_BYTES_L - 1] = 8'd0;
        end
    end

    // output register
    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (out_load) begin
            m_valid_next         = 1'b1;
            m_data_next.out_byte = ser_buf_reg[0];
            m_data_next.last     = (ser_cnt_reg == 4'd1);
            m_data_next.overflow = ser_ovf_reg;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            ser_valid_reg <= 1'b0;
            ser_cnt_reg   <= 4'd0;
            m_valid_reg   <= 1'b0;
        end else begin
            s1_valid_reg  <= s1_valid_next;
            s2_valid_reg  <= s2_valid_next;
            ser_valid_reg <= ser_valid_next;
            ser_cnt_reg   <= ser_cnt_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_ready) begin
            s1_kind_reg  <= s_data.cmd;
            s1_value_reg <= s1_value_next;
            s1_w_reg     <= s1_w_next;
            s1_neg_reg   <= s1_neg_next;
            s1_space_reg <= s_data.space_left;
        end
        if (s2_ready) begin
            s2_kind_reg  <= s1_kind_reg;
            s2_value_reg <= s1_value_reg;
            s2_neg_reg   <= s1_neg_reg;
            s2_n_reg     <= s2_n_next;
            s2_space_reg <= s1_space_reg;
        end
        ser_ovf_reg <= ser_ovf_next;
        for (int i = 0; i < MAX_BYTES_L; i++) begin
            ser_buf_reg[i] <= ser_buf_next[i];
        end
        m_data_reg <= m_data_next;
    end

    // a busy serialiser always has bytes left, never more than one encoding
    assert property (@(posedge aclk) disable iff (!aresetn)
        ser_valid_reg |-> (ser_cnt_reg != 4'd0) && (ser_cnt_reg <= 4'(MAX_BYTES_L)))
        else $error("serialiser byte count out of range");

    // an overflow item stands alone and carries a zero byte
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_data_reg.overflow)
            |-> (m_data_reg.last && m_data_reg.out_byte == 8'd0))
        else $error("overflow item malformed");

    // a stalled first stage keeps its item
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_valid_reg && !s2_ready)
            |=> (s1_valid_reg && $stable(s1_value_reg) && $stable(s1_kind_reg)))
        else $error("stage one lost its item under stall");

    // the serialiser only reloads once the previous encoding has gone out
    assert property (@(posedge aclk) disable iff (!aresetn)
        (ser_valid_reg && out_load && ser_cnt_reg != 4'd1)
            |=> (ser_cnt_reg == $past(ser_cnt_reg) - 4'd1))
        else $error("serialiser reloaded mid encoding");

    // a content length byte is never zero nor beyond nine
    assert property (@(posedge aclk) disable iff (!aresetn)
        s2_valid_reg |-> (s2_n_reg != 4'd0 && s2_n_reg <= 4'(MAX_CONTENT_L)))
        else $error("content length out of range");

endmodule
